// ===== design/ufme_pkg.sv =====
// Shared types and codes for the disjoint-set store.
`timescale 1ns / 1ps
`default_nettype none
package ufme_pkg;

    localparam int ATTR_W = 35;

    typedef struct packed {
        logic [3:0]  rank;
        logic [10:0] size;
        logic [19:0] sum;
    } attr_t;

    localparam logic [2:0] OP_INIT  = 3'd0;
    localparam logic [2:0] OP_UNION = 3'd1;
    localparam logic [2:0] OP_MOVE  = 3'd2;
    localparam logic [2:0] OP_QUERY = 3'd3;
    localparam logic [2:0] OP_ERASE = 3'd4;

    localparam logic [1:0] ST_DONE    = 2'd0;
    localparam logic [1:0] ST_NOCHG   = 2'd1;
    localparam logic [1:0] ST_FULL    = 2'd2;
    localparam logic [1:0] ST_INVALID = 2'd3;

endpackage
`default_nettype wire

// ===== design/union_find_move_erase.sv =====
// Top level of the disjoint-set store with union, move, erase and query.
// Usage: an operation (opcode, elem_a, elem_b) is a transfer on the in channel
// (in_valid/in_ready); exactly one result (set_size, set_sum, set_count,
// status) follows as a transfer on the out channel (out_valid/out_ready).
// One operation is worked on at a time. Query and erase walk the element's
// path to its root and compress it; union and move do so for two elements.
// Walks go one node per cycle through the node memory's single read port and
// are bounded by the tree rank.
// Init rewrites every entry of both memories, one entry per cycle.
// After reset the same clearing pass runs with num_elements = 1024; in_ready
// stays low for its length. cfg_we/cfg_data write num_elements at any time;
// it takes effect at the next init.
// A finished result waits in the output register; the next operation is
// taken while it waits, and its own result holds until the slot is free.
`timescale 1ns / 1ps
`default_nettype none
module union_find_move_erase #(
    parameter int MAX_ELEMENTS = 1024,
    parameter int MAX_NODES    = 4096
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        cfg_we,
    input  wire logic [10:0] cfg_data,
    input  wire logic        in_valid,
    output logic             in_ready,
    input  wire logic [2:0]  opcode,
    input  wire logic [10:0] elem_a,
    input  wire logic [10:0] elem_b,
    output logic             out_valid,
    input  wire logic        out_ready,
    output logic [10:0]      set_size,
    output logic [19:0]      set_sum,
    output logic [10:0]      set_count,
    output logic [1:0]       status
);

    localparam int NW      = $clog2(MAX_NODES);
    localparam int EAW     = $clog2(MAX_ELEMENTS + 1);
    localparam int SWD     = (MAX_NODES > MAX_ELEMENTS + 1) ? MAX_NODES : MAX_ELEMENTS + 1;
    localparam int SWW     = $clog2(SWD);
    localparam int N_LIMIT = (MAX_ELEMENTS < MAX_NODES - 1) ? MAX_ELEMENTS : MAX_NODES - 1;
    localparam int N_RST   = (1024 > N_LIMIT) ? N_LIMIT : 1024;
    localparam int RW      = NW + ufme_pkg::ATTR_W;

    localparam logic [3:0] S_SWEEP = 4'd0;
    localparam logic [3:0] S_IDLE  = 4'd1;
    localparam logic [3:0] S_MA    = 4'd2;
    localparam logic [3:0] S_MB    = 4'd3;
    localparam logic [3:0] S_WALK  = 4'd4;
    localparam logic [3:0] S_COMP  = 4'd5;
    localparam logic [3:0] S_AFTER = 4'd6;
    localparam logic [3:0] S_U2    = 4'd7;
    localparam logic [3:0] S_M2    = 4'd8;
    localparam logic [3:0] S_M3    = 4'd9;
    localparam logic [3:0] S_DONE  = 4'd10;

    logic [3:0]            state_reg, state_next;
    logic [SWW-1:0]        sw_reg, sw_next;
    logic                  init_rep_reg, init_rep_next;
    logic [10:0]           cfg_reg;
    logic [10:0]           n_reg, n_next, n_clamp;
    logic [NW-1:0]         next_free_reg, next_free_next;
    logic [10:0]           sets_reg, sets_next;
    logic [2:0]            op_reg, op_next;
    logic [10:0]           a_reg, a_next, b_reg, b_next;
    logic [NW-1:0]         nb_reg, nb_next;
    logic [NW-1:0]         cur_reg, cur_next, start_reg, start_next;
    logic                  phase_reg, phase_next;
    logic [NW-1:0]         ra_reg, ra_next, rb_reg, rb_next;
    ufme_pkg::attr_t       raat_reg, raat_next, rbat_reg, rbat_next;
    logic [10:0]           res_size_reg, res_size_next;
    logic [19:0]           res_sum_reg, res_sum_next;
    logic [1:0]            res_status_reg, res_status_next;
    logic                  out_valid_reg, out_valid_next;
    logic [10:0]           set_size_reg, set_size_next, set_count_reg, set_count_next;
    logic [19:0]           set_sum_reg, set_sum_next;
    logic [1:0]            status_reg, status_next;

    logic                  node_we;
    logic [NW-1:0]         node_waddr, node_raddr;
    logic [RW-1:0]         node_wdata, node_rdata;
    logic                  map_we;
    logic [EAW-1:0]        map_waddr, map_raddr;
    logic [NW-1:0]         map_wdata, map_rdata;

    logic [NW-1:0]         rd_par;
    ufme_pkg::attr_t       rd_attr;
    logic [NW-1:0]         root_cur;
    logic                  swap;
    logic [NW-1:0]         u_node, v_node;
    ufme_pkg::attr_t       u_attr, v_attr;
    logic [10:0]           sets_dec;
    logic                  a_in_range, b_in_range;

    ufme_ram #(.WIDTH(RW), .DEPTH(MAX_NODES)) u_node_ram (
        .clk   (clk),
        .we    (node_we),
        .waddr (node_waddr),
        .wdata (node_wdata),
        .raddr (node_raddr),
        .rdata (node_rdata)
    );

    ufme_ram #(.WIDTH(NW), .DEPTH(MAX_ELEMENTS + 1)) u_map_ram (
        .clk   (clk),
        .we    (map_we),
        .waddr (map_waddr),
        .wdata (map_wdata),
        .raddr (map_raddr),
        .rdata (map_rdata)
    );

    assign rd_par   = node_rdata[RW-1:ufme_pkg::ATTR_W];
    assign rd_attr  = ufme_pkg::attr_t'(node_rdata[ufme_pkg::ATTR_W-1:0]);
    assign root_cur = phase_reg ? rb_reg : ra_reg;
    assign swap     = rbat_reg.rank > raat_reg.rank;
    assign u_node   = swap ? rb_reg : ra_reg;
    assign v_node   = swap ? ra_reg : rb_reg;
    assign u_attr   = swap ? rbat_reg : raat_reg;
    assign v_attr   = swap ? raat_reg : rbat_reg;
    assign sets_dec = (sets_reg == 11'd0) ? 11'd0 : sets_reg - 11'd1;

    assign a_in_range = (32'(elem_a) >= 1) && (32'(elem_a) <= MAX_ELEMENTS);
    assign b_in_range = (32'(elem_b) >= 1) && (32'(elem_b) <= MAX_ELEMENTS);

    always_comb
    begin
        if (32'(cfg_reg) > N_LIMIT)
        begin
            n_clamp = 11'(N_LIMIT);
        end
        else if (cfg_reg == 11'd0)
        begin
            n_clamp = 11'd1;
        end
        else
        begin
            n_clamp = cfg_reg;
        end
    end

    always_comb
    begin
        ufme_pkg::attr_t wattr;
        logic            is_elem;
        logic [NW-1:0]   nn;

        wattr           = '0;
        is_elem         = 1'b0;
        nn              = next_free_reg + NW'(1);
        state_next      = state_reg;
        sw_next         = sw_reg;
        init_rep_next   = init_rep_reg;
        n_next          = n_reg;
        next_free_next  = next_free_reg;
        sets_next       = sets_reg;
        op_next         = op_reg;
        a_next          = a_reg;
        b_next          = b_reg;
        nb_next         = nb_reg;
        cur_next        = cur_reg;
        start_next      = start_reg;
        phase_next      = phase_reg;
        ra_next         = ra_reg;
        rb_next         = rb_reg;
        raat_next       = raat_reg;
        rbat_next       = rbat_reg;
        res_size_next   = res_size_reg;
        res_sum_next    = res_sum_reg;
        res_status_next = res_status_reg;
        node_we         = 1'b0;
        node_waddr      = '0;
        node_wdata      = '0;
        node_raddr      = '0;
        map_we          = 1'b0;
        map_waddr       = '0;
        map_wdata       = '0;
        map_raddr       = '0;
        in_ready        = 1'b0;

        out_valid_next = out_valid_reg && !out_ready;
        set_size_next  = set_size_reg;
        set_sum_next   = set_sum_reg;
        set_count_next = set_count_reg;
        status_next    = status_reg;

        case (state_reg)
            S_SWEEP:
            begin
                is_elem    = (32'(sw_reg) >= 1) && (32'(sw_reg) <= 32'(n_reg));
                wattr.size = is_elem ? 11'd1 : 11'd0;
                wattr.sum  = is_elem ? 20'(sw_reg) : 20'd0;
                node_we    = 32'(sw_reg) < MAX_NODES;
                node_waddr = NW'(sw_reg);
                node_wdata = {NW'(sw_reg), wattr};
                map_we     = 32'(sw_reg) <= MAX_ELEMENTS;
                map_waddr  = EAW'(sw_reg);
                map_wdata  = is_elem ? NW'(sw_reg) : '0;
                sw_next    = sw_reg + SWW'(1);
                if (sw_reg == SWW'(SWD - 1))
                begin
                    next_free_next = NW'(n_reg);
                    sets_next      = n_reg;
                    if (init_rep_reg)
                    begin
                        if ((32'(a_reg) >= 1) && (32'(a_reg) <= MAX_ELEMENTS)
                            && (a_reg <= n_reg))
                        begin
                            res_size_next = 11'd1;
                            res_sum_next  = 20'(a_reg);
                        end
                        else
                        begin
                            res_size_next = 11'd0;
                            res_sum_next  = 20'd0;
                        end
                        res_status_next = ufme_pkg::ST_DONE;
                        state_next      = S_DONE;
                    end
                    else
                    begin
                        state_next = S_IDLE;
                    end
                end
            end

            S_IDLE:
            begin
                in_ready        = 1'b1;
                map_raddr       = EAW'(elem_a);
                res_size_next   = 11'd0;
                res_sum_next    = 20'd0;
                res_status_next = ufme_pkg::ST_INVALID;
                if (in_valid)
                begin
                    op_next    = opcode;
                    a_next     = elem_a;
                    b_next     = elem_b;
                    phase_next = 1'b0;
                    case (opcode)
                        ufme_pkg::OP_INIT:
                        begin
                            n_next        = n_clamp;
                            sw_next       = '0;
                            init_rep_next = 1'b1;
                            state_next    = S_SWEEP;
                        end
                        ufme_pkg::OP_UNION, ufme_pkg::OP_MOVE:
                        begin
                            state_next = (a_in_range && b_in_range) ? S_MA : S_DONE;
                        end
                        ufme_pkg::OP_QUERY, ufme_pkg::OP_ERASE:
                        begin
                            state_next = a_in_range ? S_MA : S_DONE;
                        end
                        default:
                        begin
                            state_next = S_DONE;
                        end
                    endcase
                end
            end

            S_MA:
            begin
                if (map_rdata == '0)
                begin
                    res_status_next = (op_reg == ufme_pkg::OP_ERASE) ?
                                      ufme_pkg::ST_NOCHG : ufme_pkg::ST_INVALID;
                    state_next      = S_DONE;
                end
                else if (op_reg == ufme_pkg::OP_UNION || op_reg == ufme_pkg::OP_MOVE)
                begin
                    map_raddr  = EAW'(b_reg);
                    start_next = map_rdata;
                    state_next = S_MB;
                end
                else
                begin
                    cur_next   = map_rdata;
                    start_next = map_rdata;
                    node_raddr = map_rdata;
                    state_next = S_WALK;
                end
            end

            S_MB:
            begin
                if (map_rdata == '0)
                begin
                    state_next = S_DONE;
                end
                else
                begin
                    nb_next    = map_rdata;
                    cur_next   = start_reg;
                    node_raddr = start_reg;
                    state_next = S_WALK;
                end
            end

            S_WALK:
            begin
                if (rd_par == cur_reg)
                begin
                    if (phase_reg)
                    begin
                        rb_next   = cur_reg;
                        rbat_next = rd_attr;
                    end
                    else
                    begin
                        ra_next   = cur_reg;
                        raat_next = rd_attr;
                    end
                    if (cur_reg == start_reg)
                    begin
                        state_next = S_AFTER;
                    end
                    else
                    begin
                        cur_next   = start_reg;
                        node_raddr = start_reg;
                        state_next = S_COMP;
                    end
                end
                else
                begin
                    cur_next   = rd_par;
                    node_raddr = rd_par;
                end
            end

            S_COMP:
            begin
                node_we    = 1'b1;
                node_waddr = cur_reg;
                node_wdata = {root_cur, rd_attr};
                if (rd_par == root_cur)
                begin
                    state_next = S_AFTER;
                end
                else
                begin
                    cur_next   = rd_par;
                    node_raddr = rd_par;
                end
            end

            S_AFTER:
            begin
                if (!phase_reg)
                begin
                    case (op_reg)
                        ufme_pkg::OP_UNION, ufme_pkg::OP_MOVE:
                        begin
                            phase_next = 1'b1;
                            cur_next   = nb_reg;
                            start_next = nb_reg;
                            node_raddr = nb_reg;
                            state_next = S_WALK;
                        end
                        ufme_pkg::OP_QUERY:
                        begin
                            res_size_next   = raat_reg.size;
                            res_sum_next    = raat_reg.sum;
                            res_status_next = ufme_pkg::ST_DONE;
                            state_next      = S_DONE;
                        end
                        default:
                        begin
                            wattr           = raat_reg;
                            wattr.size      = raat_reg.size - 11'd1;
                            wattr.sum       = raat_reg.sum - 20'(a_reg);
                            node_we         = 1'b1;
                            node_waddr      = ra_reg;
                            node_wdata      = {ra_reg, wattr};
                            map_we          = 1'b1;
                            map_waddr       = EAW'(a_reg);
                            map_wdata       = '0;
                            res_size_next   = wattr.size;
                            res_sum_next    = wattr.sum;
                            res_status_next = ufme_pkg::ST_DONE;
                            state_next      = S_DONE;
                        end
                    endcase
                end
                else if (ra_reg == rb_reg)
                begin
                    res_size_next   = raat_reg.size;
                    res_sum_next    = raat_reg.sum;
                    res_status_next = ufme_pkg::ST_NOCHG;
                    state_next      = S_DONE;
                end
                else if (op_reg == ufme_pkg::OP_UNION)
                begin
                    node_we    = 1'b1;
                    node_waddr = v_node;
                    node_wdata = {u_node, v_attr};
                    state_next = S_U2;
                end
                else if (32'(next_free_reg) >= MAX_NODES - 1)
                begin
                    res_size_next   = raat_reg.size;
                    res_sum_next    = raat_reg.sum;
                    res_status_next = ufme_pkg::ST_FULL;
                    state_next      = S_DONE;
                end
                else
                begin
                    wattr          = raat_reg;
                    wattr.size     = raat_reg.size - 11'd1;
                    wattr.sum      = raat_reg.sum - 20'(a_reg);
                    node_we        = 1'b1;
                    node_waddr     = ra_reg;
                    node_wdata     = {ra_reg, wattr};
                    map_we         = 1'b1;
                    map_waddr      = EAW'(a_reg);
                    map_wdata      = nn;
                    next_free_next = nn;
                    state_next     = S_M2;
                end
            end

            S_U2:
            begin
                wattr      = u_attr;
                wattr.size = u_attr.size + v_attr.size;
                wattr.sum  = u_attr.sum + v_attr.sum;
                if (u_attr.rank == v_attr.rank)
                begin
                    wattr.rank = u_attr.rank + 4'd1;
                end
                node_we         = 1'b1;
                node_waddr      = u_node;
                node_wdata      = {u_node, wattr};
                res_size_next   = wattr.size;
                res_sum_next    = wattr.sum;
                res_status_next = ufme_pkg::ST_DONE;
                sets_next       = sets_dec;
                state_next      = S_DONE;
            end

            S_M2:
            begin
                node_we    = 1'b1;
                node_waddr = next_free_reg;
                if (rbat_reg.rank != 4'd0)
                begin
                    wattr.rank = 4'd0;
                    wattr.size = 11'd1;
                    wattr.sum  = 20'(a_reg);
                    node_wdata = {rb_reg, wattr};
                end
                else
                begin
                    wattr.rank = 4'd1;
                    wattr.size = rbat_reg.size + 11'd1;
                    wattr.sum  = rbat_reg.sum + 20'(a_reg);
                    node_wdata = {next_free_reg, wattr};
                end
                state_next = S_M3;
            end

            S_M3:
            begin
                node_we    = 1'b1;
                node_waddr = rb_reg;
                if (rbat_reg.rank != 4'd0)
                begin
                    wattr      = rbat_reg;
                    wattr.size = rbat_reg.size + 11'd1;
                    wattr.sum  = rbat_reg.sum + 20'(a_reg);
                    node_wdata = {rb_reg, wattr};
                end
                else
                begin
                    wattr      = rbat_reg;
                    wattr.size = rbat_reg.size + 11'd1;
                    wattr.sum  = rbat_reg.sum + 20'(a_reg);
                    node_wdata = {next_free_reg, rbat_reg};
                end
                res_size_next   = wattr.size;
                res_sum_next    = wattr.sum;
                res_status_next = ufme_pkg::ST_DONE;
                sets_next       = sets_dec;
                state_next      = S_DONE;
            end

            S_DONE:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    out_valid_next = 1'b1;
                    set_size_next  = res_size_reg;
                    set_sum_next   = res_sum_reg;
                    set_count_next = sets_reg;
                    status_next    = res_status_reg;
                    init_rep_next  = 1'b0;
                    state_next     = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_SWEEP;
            sw_reg        <= '0;
            init_rep_reg  <= 1'b0;
            cfg_reg       <= 11'd1024;
            n_reg         <= 11'(N_RST);
            next_free_reg <= NW'(N_RST);
            sets_reg      <= 11'(N_RST);
            phase_reg     <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            sw_reg        <= sw_next;
            init_rep_reg  <= init_rep_next;
            n_reg         <= n_next;
            next_free_reg <= next_free_next;
            sets_reg      <= sets_next;
            phase_reg     <= phase_next;
            out_valid_reg <= out_valid_next;
            if (cfg_we)
            begin
                cfg_reg <= cfg_data;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        op_reg         <= op_next;
        a_reg          <= a_next;
        b_reg          <= b_next;
        nb_reg         <= nb_next;
        cur_reg        <= cur_next;
        start_reg      <= start_next;
        ra_reg         <= ra_next;
        rb_reg         <= rb_next;
        raat_reg       <= raat_next;
        rbat_reg       <= rbat_next;
        res_size_reg   <= res_size_next;
        res_sum_reg    <= res_sum_next;
        res_status_reg <= res_status_next;
        set_size_reg   <= set_size_next;
        set_sum_reg    <= set_sum_next;
        set_count_reg  <= set_count_next;
        status_reg     <= status_next;
    end

    assign out_valid = out_valid_reg;
    assign set_size  = set_size_reg;
    assign set_sum   = set_sum_reg;
    assign set_count = set_count_reg;
    assign status    = status_reg;

    a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready) |=> !in_ready)
        else $error("A second operation was taken while one is in progress.");

    a_comp_not_root: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_COMP) |-> (cur_reg != root_cur))
        else $error("Path compression rewrote a root node.");

    a_free_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_IDLE) |-> (32'(next_free_reg) <= MAX_NODES - 1))
        else $error("Next free node ran past the node store.");

endmodule
`default_nettype wire

// ===== design/ufme_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps
`default_nettype none
module ufme_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule
`default_nettype wire
